FILE: rtl/sorted_list_engine_assert.svh
// Assertion macros for the sorted list engine.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sle_pkg.sv
// Shared types, widths and helpers for the sorted list engine.
// No dependencies; used by the interfaces, the cell and the top level.
package sle_pkg;

	localparam int DataW    = 32;
	localparam int PosW     = 5;
	localparam int CntOutW  = 5;
	localparam int StatusW  = 2;
	localparam int DepthDef = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} opcode_t;

	typedef enum logic [StatusW-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [DataW-1:0] value;
	} cell_ctl_t;

	// Flipping the sign bit turns a signed compare into an unsigned one.
	function automatic logic [DataW-1:0] order_key(input logic [DataW-1:0] raw);
		order_key = {~raw[DataW-1], raw[DataW-2:0]};
	endfunction

endpackage

FILE: rtl/sle_if.sv
// Request and response channel interfaces of the sorted list engine.
// Depends on sle_pkg for the field widths.
interface sle_req_if import sle_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic signed [DataW-1:0] value;
	logic [PosW-1:0]         position;

	modport source (output valid, opcode, value, position, input ready);
	modport sink (input valid, opcode, value, position, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DataW-1:0] removed_value;
	logic [StatusW-1:0]      status;
	logic [CntOutW-1:0]      entry_count;

	modport source (output valid, removed_value, status, entry_count, input ready);
	modport sink (input valid, removed_value, status, entry_count, output ready);
endinterface

FILE: rtl/sle_cell.sv
// One cell of the sorted list chain: holds a single entry and trades it
// with its neighbors on insert and delete. Depends on sle_pkg.
module sle_cell import sle_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic [CNT_W-1:0]        count,
	input  logic [PosW-1:0]         position,
	input  logic                    prev_after,
	input  logic signed [DataW-1:0] prev_entry,
	input  logic signed [DataW-1:0] next_entry,
	output logic                    after,
	output logic                    hit,
	output logic signed [DataW-1:0] entry
);

	localparam int CW = (CNT_W > PosW) ? CNT_W : PosW;
	localparam int IW = (CW > 9) ? CW : 9;

	logic signed [DataW-1:0] entry_q;
	logic                    occupied;
	logic                    del_shift;

	assign occupied  = IW'(IDX) < IW'(count);
	// A cell at or past the insert slot is either empty or holds a value not smaller.
	assign after     = !occupied || (order_key(entry_q) >= order_key(ctl.value));
	assign del_shift = IW'(IDX + 1) >= IW'(position);
	assign hit       = IW'(IDX + 1) == IW'(position);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (prev_after) begin
				entry_q <= prev_entry;
			end else if (after) begin
				entry_q <= ctl.value;
			end
		end else if (ctl.del_en && del_shift) begin
			entry_q <= next_entry;
		end
	end

endmodule

FILE: rtl/sorted_list_engine.sv
// Top level of the sorted list engine: the chain of cells, the entry count
// and the registered response. Depends on sle_pkg, sle_if, sle_cell.
//
// The engine keeps up to DEPTH signed 32-bit values in non-decreasing order
// and takes one request per clock: an insert places the value before the
// first entry that is not smaller, a delete removes the entry at a 1-based
// position and returns it. Every request gives one response the cycle after
// it is accepted, holding the new count and a status (done, list full, or
// position out of range; a rejected request leaves the list as it was).
// All cells compare against the request and shift toward their neighbor in
// the same cycle, so the row of cells sets the clock period, not the rate.
// A new request is accepted whenever the response register is empty or is
// being taken in that cycle. No clearing pass is needed after reset.
`include "sorted_list_engine_assert.svh"

module sorted_list_engine import sle_pkg::*; #(
	parameter int DEPTH = DepthDef
) (
	input  logic     clk,
	input  logic     arst_n,
	sle_req_if.sink  req,
	sle_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > PosW) ? CNT_W : PosW;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    rsp_valid_q;
	logic signed [DataW-1:0] removed_q;
	logic [StatusW-1:0]      status_q;
	logic [CntOutW-1:0]      count_out_q;

	logic                    accept;
	logic                    is_insert;
	logic                    full;
	logic                    del_ok;
	status_t                 status_next;
	logic signed [DataW-1:0] removed_next;
	cell_ctl_t               ctl;

	logic                    after_w [DEPTH];
	logic                    hit_w   [DEPTH];
	logic signed [DataW-1:0] entry_w [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_insert = req.opcode == OP_INSERT;
	assign full      = count_q == CNT_W'(DEPTH);
	assign del_ok    = (req.position != '0) && (CW'(req.position) <= CW'(count_q));

	assign ctl.ins_en = accept && is_insert && !full;
	assign ctl.del_en = accept && !is_insert && del_ok;
	assign ctl.value  = req.value;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sle_cell #(
			.IDX   (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.position   (req.position),
			.prev_after ((k == 0) ? 1'b0 : after_w[(k == 0) ? 0 : k - 1]),
			.prev_entry ((k == 0) ? req.value : entry_w[(k == 0) ? 0 : k - 1]),
			.next_entry (entry_w[(k == DEPTH - 1) ? k : k + 1]),
			.after      (after_w[k]),
			.hit        (hit_w[k]),
			.entry      (entry_w[k])
		);
	end

	// At most one cell matches the position, so the entries can be OR-ed.
	always_comb begin
		removed_next = '0;
		for (int k = 0; k < DEPTH; k++) begin
			removed_next = removed_next | (entry_w[k] & {DataW{hit_w[k]}});
		end
		if (!del_ok) begin
			removed_next = '0;
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		if (is_insert) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (del_ok) begin
				count_next = count_q - CNT_W'(1);
			end else begin
				status_next = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q   <= is_insert ? '0 : removed_next;
			status_q    <= status_next;
			count_out_q <= CntOutW'(count_next);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.entry_count   = count_out_q;

	`SLE_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`SLE_ASSERT(a_full_holds, accept && is_insert && full |=> $stable(count_q),
		"insert into full list changed the count")
	`SLE_ASSERT(a_insert_grows, ctl.ins_en |=> count_q == $past(count_q) + CNT_W'(1),
		"accepted insert did not grow the count")
	`SLE_ASSERT(a_reject_zero, rsp_valid_q && (status_q != ST_DONE) |-> removed_q == '0,
		"rejected request returned a nonzero value")

endmodule

FILE: tb/sle_list_checker.sv
// Checker for the sorted list engine: watches both channels and keeps its own sorted list.
// It predicts every response and compares it with what the engine returns.
// Depends on sle_pkg and the channel interfaces in sle_if.
module sle_list_checker import sle_pkg::*; #(
	parameter int DEPTH = DepthDef
) (
	input  logic clk,
	input  logic arst_n,
	sle_req_if   req,
	sle_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic signed [DataW-1:0] removed;
		status_t                 status;
		logic [CntOutW-1:0]      count;
	} list_result_t;

	logic signed [DataW-1:0] list_vals [DEPTH];
	int                      n_entries;
	list_result_t            awaited_results [$];
	int                      mismatches = 0;

	// Applies one request to the shadow list and returns the response it should give.
	function automatic list_result_t list_update(input opcode_t op,
			input logic signed [DataW-1:0] val, input logic [PosW-1:0] pos);
		list_result_t res;
		int slot;
		int k;
		res.removed = '0;
		res.status  = ST_DONE;
		if (op == OP_INSERT) begin
			if (n_entries >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// A new value lands in front of any stored entries equal to it.
				slot = 0;
				while (slot < n_entries && list_vals[slot] < val)
					slot++;
				for (k = n_entries; k > slot; k--)
					list_vals[k] = list_vals[k-1];
				list_vals[slot] = val;
				n_entries++;
			end
		end else begin
			if (pos == 0 || int'(pos) > n_entries) begin
				res.status = ST_RANGE;
			end else begin
				slot = int'(pos) - 1;
				res.removed = list_vals[slot];
				for (k = slot; k + 1 < n_entries; k++)
					list_vals[k] = list_vals[k+1];
				n_entries--;
			end
		end
		res.count = n_entries[CntOutW-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			n_entries = 0;
			awaited_results.delete();
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			// The response leaving at this edge always belongs to an earlier request.
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("response with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.removed_value !== want.removed) begin
						$error("removed_value: expected %0d, got %0d",
							want.removed, rsp.removed_value);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %s, got %0d", want.status.name(), rsp.status);
						mismatches++;
					end
					if (rsp.entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, rsp.entry_count);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_results.push_back(list_update(opcode_t'(req.opcode), req.value,
					req.position));
			pending    <= awaited_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: tb/sorted_list_engine_tb.sv
// Top of the sorted list engine testbench: clock, reset, request stimulus and response stalls.
// Depends on sle_pkg, sle_if, the engine RTL and sle_list_checker for the comparison.
module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int Depth          = DepthDef;
	localparam int RandomRequests = 850;
	localparam int CycleLimit     = 400000;
	localparam int HoldAt         = 250;
	localparam int HoldCycles     = 300;
	localparam int PauseAt        = 600;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent = 0;
	int   cycles = 0;

	sle_req_if req_ch ();
	sle_rsp_if rsp_ch ();

	sorted_list_engine #(.DEPTH(Depth)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sle_list_checker #(.DEPTH(Depth)) list_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Every third block of 64 requests runs with no gaps at all.
	function automatic int pick_gap();
		int r;
		if ((sent / 64) % 3 == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Extremes, a narrow band that produces many equal values, and the full range.
	function automatic logic signed [DataW-1:0] rand_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		if (sel <= 3)
			return $signed($urandom_range(0, 8)) - 32'sd4;
		return $urandom;
	endfunction

	function automatic logic [PosW-1:0] rand_pos();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return PosW'($urandom_range(0, 31));
		if (sel == 1)
			return '0;
		return PosW'($urandom_range(1, Depth));
	endfunction

	// Offers one request from a falling edge and returns at the falling edge after acceptance.
	task automatic send_req(input opcode_t op, input logic signed [DataW-1:0] val,
			input logic [PosW-1:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.value    <= val;
		req_ch.position <= pos;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		while (cycles < CycleLimit)
			@(posedge clk) cycles++;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Response side: stretches of steady, light and heavy stalling, plus one long hold-off.
	initial begin
		int low_left;
		int stretch_left;
		int stretch_kind;
		int r;
		bit hold_done;
		low_left     = 0;
		stretch_left = 0;
		stretch_kind = 0;
		hold_done    = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent >= HoldAt) begin
				// The sender keeps going, so the response register fills and the engine stops taking requests.
				rsp_ch.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 120);
					stretch_kind = $urandom_range(0, 2);
				end
				stretch_left--;
				if (low_left > 0) begin
					low_left--;
					rsp_ch.ready <= 1'b0;
				end else if (stretch_kind == 0) begin
					rsp_ch.ready <= 1'b1;
				end else begin
					r = $urandom_range(0, 99);
					if (r < ((stretch_kind == 1) ? 20 : 50)) begin
						rsp_ch.ready <= 1'b0;
						low_left = ($urandom_range(0, 19) == 0) ?
							$urandom_range(10, 40) : $urandom_range(0, 2);
					end else begin
						rsp_ch.ready <= 1'b1;
					end
				end
			end
		end
	end

	initial begin
		int k;
		int insert_pct;
		insert_pct      = 50;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.opcode   <= OP_INSERT;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Deletes on an empty list, extremes and an equal value, then deletes out of range and at both ends.
		send_req(OP_DELETE, 32'sd0, 5'd0);
		send_req(OP_DELETE, 32'sd0, 5'd1);
		send_req(OP_INSERT, 32'sh7fff_ffff, 5'd0);
		send_req(OP_INSERT, 32'sh8000_0000, 5'd31);
		send_req(OP_INSERT, 32'sd0, 5'd0);
		send_req(OP_INSERT, -32'sd1, 5'd0);
		send_req(OP_INSERT, 32'sd0, 5'd0);
		send_req(OP_DELETE, 32'sh7fff_ffff, 5'd0);
		send_req(OP_DELETE, -32'sd1, 5'd31);
		send_req(OP_DELETE, 32'sd0, 5'd6);
		send_req(OP_DELETE, 32'sd0, 5'd5);
		send_req(OP_DELETE, 32'sd0, 5'd1);
		// Fill the list to the top, then push past it and probe its last position.
		for (k = 0; k < Depth - 3; k++)
			send_req(OP_INSERT, rand_value(), 5'd0);
		send_req(OP_INSERT, 32'sd5, 5'd0);
		send_req(OP_DELETE, 32'sd0, 5'd17);
		send_req(OP_DELETE, 32'sd0, 5'd16);

		// Phases lean toward inserts or deletes or stay balanced, so the fill level sweeps empty to full.
		for (k = 0; k < RandomRequests; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 15;
					default: insert_pct = 50;
				endcase
			end
			if (k == PauseAt) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
				while (pending != 0)
					@(negedge clk);
			end
			if ($urandom_range(1, 100) <= insert_pct)
				send_req(OP_INSERT, rand_value(), rand_pos());
			else
				send_req(OP_DELETE, rand_value(), rand_pos());
		end
		req_ch.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_if.sv
rtl/sle_cell.sv
rtl/sorted_list_engine.sv
tb/sle_list_checker.sv
tb/sorted_list_engine_tb.sv
